// ----- rtl/pdbp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdbp_pkg: shared types and constants
// Operation codes, per-item command format and fixed levels of the PCM player.
// ----------------------------------------------------------------------------
package pdbp_pkg;

    localparam int IN_W  = 40;
    localparam int OUT_W = 24;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [7:0] IDLE_LEVEL  = 8'd127;
    localparam logic [7:0] END_LEVEL_A = 8'h7F;
    localparam logic [7:0] END_LEVEL_B = 8'hFF;
    localparam logic [7:0] SIGN_FLIP   = 8'h80;

    localparam logic CFG_SIXTEEN_BIT = 1'b0;
    localparam logic CFG_KEEP_LOW    = 1'b1;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_START  = 3'd1,
        OP_REFILL = 3'd2,
        OP_TICK   = 3'd3,
        OP_STOP   = 3'd4
    } op_t;

    // what the back end does with the levels for one item
    typedef enum logic [2:0] {
        K_HOLD       = 3'd0,
        K_SAMPLE8    = 3'd1,
        K_SAMPLE16_S = 3'd2,
        K_SAMPLE16_H = 3'd3,
        K_HALT_IDLE  = 3'd4,
        K_HALT_WIDE  = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] lo;
        logic [7:0] hi;
        logic       running;
        logic       refill;
        logic       target;
    } cmd_t;

endpackage

// ----- rtl/pcm_double_buffer_pwm_player.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_double_buffer_pwm_player: ping-pong PCM buffers to PWM duty values
//
// channel   dir  handshake                payload
// s_axis    in   s_tvalid / s_tready      s_tdata: op, buffer, index, byte, fills
// m_axis    out  m_tvalid / m_tready      m_tdata: duty_a, duty_b, status flags
// cfg       in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One item per cycle while the output accepts results; each result passes from
// the fetch stage into the queue and from the queue into the result register.
// Reset is asynchronous; the sample store is not cleared and needs no sweep.
// Upstream stalls only when the four-entry queue and the fetch stage are full.
// ----------------------------------------------------------------------------
module pcm_double_buffer_pwm_player
    import pdbp_pkg::*;
#(
    parameter int BUFFER_BYTES = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // [2:0] operation, [3] buffer_select, [11:4] byte_index, [19:12] data_byte,
    // [28:20] fill_count, [37:29] second_fill_count
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // [7:0] duty_a, [15:8] duty_b, [16] is_active, [17] refill_request,
    // [18] refill_target
    output logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [0:0]       cfg_index,
    input  logic             cfg_data
);

    logic st_valid, st_push, q_full, q_valid, q_pop;
    cmd_t st_cmd, q_cmd;

    assign cfg_ready = 1'b1;

    pdbp_front #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .operation        (s_tdata[2:0]),
        .buffer_select    (s_tdata[3]),
        .byte_index       (s_tdata[11:4]),
        .data_byte        (s_tdata[19:12]),
        .fill_count       (s_tdata[28:20]),
        .second_fill_count(s_tdata[37:29]),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .q_full           (q_full),
        .st_valid         (st_valid),
        .st_push          (st_push),
        .st_cmd           (st_cmd)
    );

    pdbp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (st_push),
        .push_cmd (st_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_valid(q_valid),
        .pop_cmd  (q_cmd)
    );

    pdbp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

`ifndef SYNTHESIS
    // a transfer always lands in the fetch stage
    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> st_valid)
        else $error("accepted item missing from fetch stage");

    // a refill is only requested while playing
    a_refill_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[17] && !m_tdata[16]))
        else $error("refill request while idle");

    // the stage only moves on when the queue can take it
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (q_full && !q_pop) |=> !(q_valid && !q_full && !q_pop && !st_push && !st_valid))
        else $error("queue state inconsistent");
`endif

endmodule

// ----- rtl/pdbp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdbp_front: playback control and sample store
// Decodes each item, updates the playback state at once and fetches the
// sample bytes; the fetched item waits in one stage until the queue takes it.
// ----------------------------------------------------------------------------
module pdbp_front
    import pdbp_pkg::*;
#(
    parameter int BUFFER_BYTES = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] operation,
    input  logic       buffer_select,
    input  logic [7:0] byte_index,
    input  logic [7:0] data_byte,
    input  logic [8:0] fill_count,
    input  logic [8:0] second_fill_count,
    input  logic       cfg_valid,
    input  logic [0:0] cfg_index,
    input  logic       cfg_data,
    input  logic       q_full,
    output logic       st_valid,
    output logic       st_push,
    output cmd_t       st_cmd
);

    localparam int STORE = 2 * BUFFER_BYTES;
    localparam int AW    = $clog2(STORE);
    localparam int SW    = AW + 1;
    localparam int PW    = $clog2(BUFFER_BYTES + 1);
    localparam int CW    = (PW > 9) ? PW : 9;
    localparam int RW    = PW + 1;

    logic [7:0] store_mem [STORE];

    logic          side_reg, side_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [PW-1:0] stop_pos_reg, stop_pos_next;
    logic          stop_known_reg, stop_known_next;
    logic [PW-1:0] pend_pos_reg, pend_pos_next;
    logic          pend_known_reg, pend_known_next;
    logic          refill_reg, refill_next;
    logic          running_reg, running_next;
    logic          sixteen_reg, keep_low_reg;

    logic          st_valid_reg, st_valid_next;
    kind_t         st_kind_reg, st_kind_next;
    logic          st_running_reg, st_refill_reg, st_target_reg;
    logic [7:0]    lo_reg, hi_reg;

    logic          accept;
    logic          fill_lt, fill2_lt, idx_ok;
    logic [RW-1:0] rp_adv;
    logic          rd_side;
    logic [PW-1:0] rd_pos;
    logic [SW-1:0] base, a0_raw, a1_raw;
    logic [AW-1:0] rd_addr0, rd_addr1, wr_addr;
    logic          wr_en;
    kind_t         sample_kind;

    assign in_ready = !st_valid_reg || !q_full;
    assign accept   = in_valid && in_ready;
    assign st_push  = st_valid_reg && !q_full;

    assign fill_lt  = CW'(fill_count) < CW'(BUFFER_BYTES);
    assign fill2_lt = CW'(second_fill_count) < CW'(BUFFER_BYTES);
    assign idx_ok   = CW'(byte_index) < CW'(BUFFER_BYTES);

    assign sample_kind = sixteen_reg ? (keep_low_reg ? K_SAMPLE16_S : K_SAMPLE16_H) : K_SAMPLE8;

    // read addresses; the high byte of a pair may wrap into the other buffer
    assign rd_side = (op_t'(operation) == OP_START) ? 1'b0 : side_reg;
    assign rd_pos  = (op_t'(operation) == OP_START) ? '0 : rp_reg;
    assign base    = rd_side ? SW'(BUFFER_BYTES) : '0;
    assign a0_raw  = base + SW'(rd_pos);
    assign a1_raw  = a0_raw + SW'(1);
    assign rd_addr0 = (a0_raw >= SW'(STORE)) ? AW'(a0_raw - SW'(STORE)) : AW'(a0_raw);
    assign rd_addr1 = (a1_raw >= SW'(STORE)) ? AW'(a1_raw - SW'(STORE)) : AW'(a1_raw);

    assign wr_addr = AW'((buffer_select ? SW'(BUFFER_BYTES) : SW'(0)) + SW'(byte_index));
    assign wr_en   = accept && (op_t'(operation) == OP_LOAD) && idx_ok;

    assign rp_adv = {1'b0, rp_reg} + (sixteen_reg ? RW'(2) : RW'(1));

    always_comb
    begin
        side_next       = side_reg;
        rp_next         = rp_reg;
        stop_pos_next   = stop_pos_reg;
        stop_known_next = stop_known_reg;
        pend_pos_next   = pend_pos_reg;
        pend_known_next = pend_known_reg;
        refill_next     = refill_reg;
        running_next    = running_reg;
        st_kind_next    = K_HOLD;
        case (op_t'(operation))
            OP_START:
            begin
                if (fill_lt)
                begin
                    stop_pos_next   = PW'(fill_count);
                    stop_known_next = 1'b1;
                    pend_pos_next   = PW'(fill_count);
                    pend_known_next = 1'b1;
                end
                else
                begin
                    stop_known_next = 1'b0;
                    pend_known_next = fill2_lt;
                    pend_pos_next   = fill2_lt ? PW'(second_fill_count) : '0;
                end
                side_next    = 1'b0;
                refill_next  = 1'b0;
                running_next = 1'b1;
                rp_next      = sixteen_reg ? PW'(2) : PW'(1);
                st_kind_next = sample_kind;
            end
            OP_REFILL:
            begin
                if (refill_reg)
                begin
                    pend_known_next = fill_lt;
                    pend_pos_next   = fill_lt ? PW'(fill_count) : '0;
                    refill_next     = 1'b0;
                end
            end
            OP_TICK:
            begin
                if (running_reg)
                begin
                    if (stop_known_reg && (rp_reg >= stop_pos_reg))
                    begin
                        running_next = 1'b0;
                        refill_next  = 1'b0;
                        st_kind_next = sixteen_reg ? K_HALT_WIDE : K_HALT_IDLE;
                    end
                    else
                    begin
                        st_kind_next = sample_kind;
                        if (rp_adv >= RW'(BUFFER_BYTES))
                        begin
                            if (refill_reg)
                            begin
                                // underrun: replay the last pair
                                rp_next = PW'(rp_adv - RW'(2));
                            end
                            else
                            begin
                                if (pend_known_reg)
                                begin
                                    stop_pos_next   = pend_pos_reg;
                                    stop_known_next = 1'b1;
                                end
                                else
                                begin
                                    refill_next = 1'b1;
                                end
                                side_next = ~side_reg;
                                rp_next   = '0;
                            end
                        end
                        else
                        begin
                            rp_next = PW'(rp_adv);
                        end
                    end
                end
            end
            OP_STOP:
            begin
                running_next = 1'b0;
                refill_next  = 1'b0;
                st_kind_next = K_HALT_IDLE;
            end
            default:
            begin
                st_kind_next = K_HOLD;
            end
        endcase
    end

    always_comb
    begin
        st_valid_next = st_valid_reg;
        if (accept)
            st_valid_next = 1'b1;
        else if (st_push)
            st_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg       <= 1'b0;
            rp_reg         <= '0;
            stop_pos_reg   <= '0;
            stop_known_reg <= 1'b0;
            pend_pos_reg   <= '0;
            pend_known_reg <= 1'b0;
            refill_reg     <= 1'b0;
            running_reg    <= 1'b0;
            sixteen_reg    <= 1'b0;
            keep_low_reg   <= 1'b1;
            st_valid_reg   <= 1'b0;
            st_kind_reg    <= K_HOLD;
            st_running_reg <= 1'b0;
            st_refill_reg  <= 1'b0;
            st_target_reg  <= 1'b1;
        end
        else
        begin
            st_valid_reg <= st_valid_next;
            if (cfg_valid)
            begin
                if (cfg_index == CFG_SIXTEEN_BIT)
                    sixteen_reg <= cfg_data;
                else
                    keep_low_reg <= cfg_data;
            end
            if (accept)
            begin
                side_reg       <= side_next;
                rp_reg         <= rp_next;
                stop_pos_reg   <= stop_pos_next;
                stop_known_reg <= stop_known_next;
                pend_pos_reg   <= pend_pos_next;
                pend_known_reg <= pend_known_next;
                refill_reg     <= refill_next;
                running_reg    <= running_next;
                st_kind_reg    <= st_kind_next;
                st_running_reg <= running_next;
                st_refill_reg  <= refill_next;
                st_target_reg  <= ~side_next;
            end
        end
    end

    // sample store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= data_byte;
        if (accept)
        begin
            lo_reg <= store_mem[rd_addr0];
            hi_reg <= store_mem[rd_addr1];
        end
    end

    assign st_valid       = st_valid_reg;
    assign st_cmd.kind    = st_kind_reg;
    assign st_cmd.lo      = lo_reg;
    assign st_cmd.hi      = hi_reg;
    assign st_cmd.running = st_running_reg;
    assign st_cmd.refill  = st_refill_reg;
    assign st_cmd.target  = st_target_reg;

endmodule

// ----- rtl/pdbp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdbp_queue: command queue
// Short FIFO between the control front end and the level back end.
// ----------------------------------------------------------------------------
module pdbp_queue
    import pdbp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_cmd
);

    cmd_t              entry_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = entry_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ----- rtl/pdbp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdbp_back: duty levels and result register
// Applies each command to the held PWM levels and presents the result.
// ----------------------------------------------------------------------------
module pdbp_back
    import pdbp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  cmd_t             q_cmd,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] level_a_reg, level_a_next;
    logic [7:0] level_b_reg, level_b_next;
    logic       active_reg, refill_reg, target_reg;
    logic [7:0] hi_offset;

    assign q_pop     = q_valid && (!out_valid_reg || m_tready);
    assign hi_offset = q_cmd.hi ^ SIGN_FLIP;

    always_comb
    begin
        level_a_next = level_a_reg;
        level_b_next = level_b_reg;
        case (q_cmd.kind)
            K_SAMPLE8:
            begin
                level_a_next = q_cmd.lo;
                level_b_next = q_cmd.lo;
            end
            K_SAMPLE16_S:
            begin
                level_a_next = hi_offset;
                level_b_next = q_cmd.lo;
            end
            K_SAMPLE16_H:
            begin
                level_a_next = hi_offset;
                level_b_next = hi_offset;
            end
            K_HALT_IDLE:
            begin
                level_a_next = IDLE_LEVEL;
                level_b_next = IDLE_LEVEL;
            end
            K_HALT_WIDE:
            begin
                level_a_next = END_LEVEL_A;
                level_b_next = END_LEVEL_B;
            end
            default:
            begin
                level_a_next = level_a_reg;
                level_b_next = level_b_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            level_a_reg   <= IDLE_LEVEL;
            level_b_reg   <= IDLE_LEVEL;
            active_reg    <= 1'b0;
            refill_reg    <= 1'b0;
            target_reg    <= 1'b1;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                level_a_reg <= level_a_next;
                level_b_reg <= level_b_next;
                active_reg  <= q_cmd.running;
                refill_reg  <= q_cmd.refill;
                target_reg  <= q_cmd.target;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, target_reg, refill_reg, active_reg, level_b_reg, level_a_reg};

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for pcm_double_buffer_pwm_player
// Loads both sample buffers, then plays streams through the ping-pong scheme
// in 8-bit and 16-bit modes. Every item gets one duty/status word, which is
// checked against a cycle-free model of the player kept in this bench.
// Sender and receiver idle at random, and one long output hold-off backs the
// block up.
// ----------------------------------------------------------------------------
module tb;
    import pdbp_pkg::*;

    localparam int BUF              = 256;
    localparam int DRAIN_CYCLES     = 8;
    localparam int STALL_LIMIT      = 2000;
    localparam int HOLD_CYCLES      = 120;
    localparam int PHASE_ITEMS      = 170;
    localparam logic [2:0] FIRST_UNUSED_OP = 3'd5;
    // per random phase: sixteen_bit_mode and keep_low_byte, phase 0 in bit 0
    localparam logic [5:0] MODE16_SEQ = 6'b010110;
    localparam logic [5:0] KEEP_SEQ   = 6'b100011;

    typedef struct packed {
        logic [8:0] fill2;
        logic [8:0] fill;
        logic [7:0] data;
        logic [7:0] idx;
        logic       sel;
        logic [2:0] op;
    } item_t;

    typedef struct packed {
        logic [7:0] duty_a;
        logic [7:0] duty_b;
        logic       active;
        logic       refill;
        logic       target;
    } duty_status_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [0:0]       cfg_index = '0;
    logic             cfg_data = 1'b0;

    pcm_double_buffer_pwm_player #(.BUFFER_BYTES(BUF)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // player model
    // ------------------------------------------------------------------
    logic [7:0]  sample_mem [0:2*BUF-1];
    logic        play_side = 1'b0;
    int unsigned play_pos = 0;
    int unsigned end_pos = 0;
    bit          end_known = 0;
    int unsigned next_end_pos = 0;
    bit          next_end_known = 0;
    bit          refill_pending = 0;
    bit          playing = 0;
    logic [7:0]  lvl_a = IDLE_LEVEL;
    logic [7:0]  lvl_b = IDLE_LEVEL;
    logic        mode16 = 1'b0;
    logic        keep_lo = 1'b1;

    duty_status_t duty_queue [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_requests = 0;
    int hold_off_seen = 0;
    int hold_count = 0;
    int stall_cycles = 0;
    int mismatch_count = 0;

    function automatic logic [7:0] stored_byte(int unsigned pos);
        return sample_mem[(int'(play_side) * BUF + pos) % (2 * BUF)];
    endfunction

    function automatic void play_sample();
        logic [7:0] lo;
        logic [7:0] hi;
        if (mode16)
        begin
            lo = stored_byte(play_pos);
            hi = stored_byte(play_pos + 1) ^ SIGN_FLIP;
            lvl_a = hi;
            lvl_b = keep_lo ? lo : hi;
            play_pos += 2;
        end
        else
        begin
            lvl_a = stored_byte(play_pos);
            lvl_b = lvl_a;
            play_pos += 1;
        end
    endfunction

    function automatic void halt_player(logic [7:0] a, logic [7:0] b);
        lvl_a = a;
        lvl_b = b;
        playing = 0;
        refill_pending = 0;
    endfunction

    function automatic duty_status_t advance_player(item_t it);
        int unsigned  f1;
        int unsigned  f2;
        duty_status_t res;
        f1 = (it.fill > BUF) ? BUF : it.fill;
        f2 = (it.fill2 > BUF) ? BUF : it.fill2;
        case (it.op)
            OP_LOAD:
                if (it.idx < BUF)
                    sample_mem[int'(it.sel) * BUF + int'(it.idx)] = it.data;
            OP_START:
            begin
                if (f1 < BUF)
                begin
                    end_pos = f1;
                    end_known = 1;
                    next_end_pos = f1;
                    next_end_known = 1;
                end
                else
                begin
                    end_known = 0;
                    next_end_known = (f2 < BUF);
                    next_end_pos = next_end_known ? f2 : 0;
                end
                play_side = 1'b0;
                refill_pending = 0;
                playing = 1;
                play_pos = 0;
                play_sample();
            end
            OP_REFILL:
                if (refill_pending)
                begin
                    next_end_known = (f1 < BUF);
                    next_end_pos = next_end_known ? f1 : 0;
                    refill_pending = 0;
                end
            OP_TICK:
                if (playing)
                begin
                    if (end_known && play_pos >= end_pos)
                    begin
                        if (mode16)
                            halt_player(END_LEVEL_A, END_LEVEL_B);
                        else
                            halt_player(IDLE_LEVEL, IDLE_LEVEL);
                    end
                    else
                    begin
                        play_sample();
                        if (play_pos >= BUF)
                        begin
                            // underrun: replay the last two bytes until refilled
                            if (refill_pending)
                                play_pos -= 2;
                            else
                            begin
                                if (next_end_known)
                                begin
                                    end_pos = next_end_pos;
                                    end_known = 1;
                                end
                                else
                                    refill_pending = 1;
                                play_side = ~play_side;
                                play_pos = 0;
                            end
                        end
                    end
                end
            OP_STOP:
                halt_player(IDLE_LEVEL, IDLE_LEVEL);
            default: ;
        endcase
        res.duty_a = lvl_a;
        res.duty_b = lvl_b;
        res.active = playing;
        res.refill = refill_pending;
        res.target = ~play_side;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic item_t random_item(logic [2:0] op);
        item_t it;
        it.op    = op;
        it.sel   = 1'($urandom_range(0, 1));
        it.idx   = 8'($urandom_range(0, 255));
        it.data  = 8'($urandom_range(0, 255));
        it.fill  = 9'($urandom_range(0, 511));
        it.fill2 = 9'($urandom_range(0, 511));
        return it;
    endfunction

    // full (or oversized) count with the given odds, else a short one
    function automatic logic [8:0] random_fill(int full_pct);
        logic [8:0] f;
        if ($urandom_range(0, 99) < full_pct)
            f = 9'($urandom_range(BUF, 511));
        else
            f = 9'($urandom_range(0, BUF - 1));
        return f;
    endfunction

    task automatic send_item(input item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= {{(IN_W - $bits(item_t)){1'b0}}, it};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        duty_queue.push_back(advance_player(it));
    endtask

    task automatic send_cmd(input logic [2:0] op, input logic [8:0] f1, input logic [8:0] f2);
        item_t it;
        it = random_item(op);
        it.fill = f1;
        it.fill2 = f2;
        send_item(it);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (duty_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input logic m16, input logic keep);
        drain_results();
        cfg_index <= CFG_SIXTEEN_BIT;
        cfg_data  <= m16;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mode16 = m16;
        cfg_index <= CFG_KEEP_LOW;
        cfg_data  <= keep;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        keep_lo = keep;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_preload();
        item_t it;
        for (int s = 0; s < 2; s++)
        begin
            for (int i = 0; i < BUF; i++)
            begin
                it = random_item(OP_LOAD);
                it.sel = 1'(s);
                it.idx = 8'(i);
                if (s == 0 && i == 0)
                    it.data = 8'h00;
                else if (s == 1 && i == BUF - 1)
                    it.data = 8'hFF;
                send_item(it);
            end
        end
    endtask

    task automatic test_directed();
        logic [2:0] op;
        item_t      it;
        op = FIRST_UNUSED_OP;
        send_cmd(OP_TICK, 9'h1FF, 9'h000);     // tick while idle
        repeat (3)
        begin
            send_cmd(op, 9'h000, 9'h1FF);
            op++;
        end
        send_cmd(OP_REFILL, 9'h000, 9'h000);   // refill nobody asked for
        send_cmd(OP_STOP, 9'h1FF, 9'h1FF);
        send_cmd(OP_START, 9'h000, 9'h1FF);    // empty stream ends on first tick
        send_cmd(OP_TICK, 9'h000, 9'h000);
        send_cmd(OP_START, 9'd2, 9'h000);
        repeat (3) send_cmd(OP_TICK, 9'h000, 9'h000);
        send_cmd(OP_START, 9'h1FF, 9'h1FF);    // oversized counts clamp
        repeat (2) send_cmd(OP_TICK, 9'h1FF, 9'h1FF);
        send_cmd(OP_STOP, 9'h000, 9'h000);
        send_cmd(OP_START, 9'd256, 9'd3);
        send_cmd(OP_TICK, 9'h000, 9'h000);
        it = random_item(OP_LOAD);
        it.sel = 1'b1;
        it.idx = 8'hFF;
        it.data = 8'hFF;
        send_item(it);
        it.sel = 1'b0;
        it.idx = 8'h00;
        it.data = 8'h00;
        send_item(it);
        set_mode(1'b1, 1'b1);
        send_cmd(OP_START, 9'h1FF, 9'h000);
        send_cmd(OP_TICK, 9'h000, 9'h000);
        set_mode(1'b1, 1'b0);
        send_cmd(OP_TICK, 9'h000, 9'h000);
        send_cmd(OP_START, 9'd1, 9'd256);      // 16-bit end levels
        repeat (2) send_cmd(OP_TICK, 9'h000, 9'h000);
        send_cmd(OP_STOP, 9'h000, 9'h000);
    endtask

    // leave an odd read position at the buffer end in 8-bit mode, then switch
    // to 16-bit so the high byte comes from the start of the other buffer
    task automatic test_pair_wrap();
        set_mode(1'b0, 1'b1);
        send_cmd(OP_START, 9'd300, 9'd256);
        repeat (BUF - 2) send_cmd(OP_TICK, 9'($urandom_range(0, 511)), 9'h000);
        set_mode(1'b1, 1'b1);
        repeat (2) send_cmd(OP_TICK, 9'h000, 9'h000);
    endtask

    task automatic test_backpressure();
        drain_results();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_requests++;
        send_cmd(OP_START, 9'd256, 9'd256);
        repeat (40) send_cmd(OP_TICK, 9'($urandom_range(0, 511)), 9'h000);
    endtask

    task automatic test_random_playback();
        int    sent;
        int    r;
        bit    lazy;
        item_t it;
        item_t ld;
        lazy = 0;
        for (int p = 0; p < 6; p++)
        begin
            set_mode(MODE16_SEQ[p], KEEP_SEQ[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 999);
                it = random_item(OP_TICK);
                if (!playing || r < 2)
                begin
                    it.op = OP_START;
                    it.fill = random_fill(75);
                    it.fill2 = random_fill(50);
                    // some streams leave refills late enough to underrun
                    lazy = ($urandom_range(0, 3) == 0);
                end
                else if (r < 3)
                    it.op = OP_STOP;
                else if (r < 40)
                begin
                    if ($urandom_range(0, 3) == 0)
                        it.op = OP_REFILL;
                    else
                        it.op = 3'(FIRST_UNUSED_OP + $urandom_range(0, 2));
                    sent--;
                end
                else if (refill_pending && r < (lazy ? 45 : 300))
                begin
                    repeat ($urandom_range(0, 3))
                    begin
                        ld = random_item(OP_LOAD);
                        ld.sel = ~play_side;
                        send_item(ld);
                        sent++;
                    end
                    it.op = OP_REFILL;
                    it.fill = random_fill(80);
                end
                else if (r < 340)
                    it.op = OP_LOAD;
                send_item(it);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // output side: random stalls, one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_off_seen != hold_off_requests)
        begin
            hold_off_seen <= hold_off_requests;
            hold_count <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_count > 0)
        begin
            hold_count <= hold_count - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        duty_status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (duty_queue.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected result transfer: %06h", m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = duty_queue.pop_front();
                if (m_tdata[7:0] !== want.duty_a || m_tdata[15:8] !== want.duty_b ||
                    m_tdata[16] !== want.active || m_tdata[17] !== want.refill ||
                    m_tdata[18] !== want.target)
                begin
                    if (mismatch_count < 10)
                        $display("duty mismatch: expected a=%02h b=%02h act=%0b req=%0b tgt=%0b, got a=%02h b=%02h act=%0b req=%0b tgt=%0b",
                                 want.duty_a, want.duty_b, want.active, want.refill,
                                 want.target, m_tdata[7:0], m_tdata[15:8], m_tdata[16],
                                 m_tdata[17], m_tdata[18]);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: cycles without any transfer on any channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("pcm_double_buffer_pwm_player: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_preload();
        test_directed();
        test_pair_wrap();
        test_backpressure();
        test_random_playback();
        drain_results();
        if (mismatch_count == 0 && duty_queue.size() == 0)
            $display("pcm_double_buffer_pwm_player: match");
        else
            $display("pcm_double_buffer_pwm_player: mismatch");
        $finish;
    end

endmodule
